// ----- sv/vpid_pkg.sv -----
// ----------------------------------------------------------------------------
// vpid_pkg
// Shared widths, register indexes and types for the incremental PID block
// with output slew limiting.
// ----------------------------------------------------------------------------
package vpid_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int STEP_WIDTH      = 31;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]   csr_index_type;

   // Configuration register indexes.
   localparam csr_index_type CSR_PROPORTIONAL_GAIN = 3'd0;
   localparam csr_index_type CSR_INTEGRAL_GAIN     = 3'd1;
   localparam csr_index_type CSR_DERIVATIVE_GAIN   = 3'd2;
   localparam csr_index_type CSR_TARGET_LEVEL      = 3'd3;
   localparam csr_index_type CSR_MIN_OUTPUT        = 3'd4;
   localparam csr_index_type CSR_MAX_OUTPUT        = 3'd5;
   localparam csr_index_type CSR_MAX_STEP          = 3'd6;

   // Request function codes.
   localparam logic FUNC_SAMPLE  = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   localparam word_type WORD_MIN = 32'sh8000_0000;
   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic [STEP_WIDTH-1:0] STEP_MAX = 31'h7FFF_FFFF;

endpackage

// ----- sv/velocity_pid_with_slew_limit.sv -----
// ----------------------------------------------------------------------------
// velocity_pid_with_slew_limit
// Incremental (velocity-form) PID controller in signed fixed point, with
// output range clamp and per-sample slew limit.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one beat per sample: req_func selects a new
//   measurement or a restart, req_sample_value carries the measurement or the
//   start value. Each request beat yields exactly one rsp_ beat with the new
//   drive value and the two limit flags, in request order.
//   A beat is taken into an input register, and the whole update (error,
//   three gain products, sum, clamp and slew limit) is worked out in one pass
//   into the result register. The request sits in the input register until the
//   result register is empty or being emptied, then moves into it. One beat per
//   cycle is sustained while the receiver does not stall; the loop through the
//   stored last drive and errors closes within that single pass.
//   A waiting result does not block the input register: a new request is
//   taken whenever the result register is empty or being emptied. When the
//   receiver stalls, the result holds and the input register fills, after
//   which req_stall rises.
//   Reset empties both registers, clears the controller state and returns the
//   configuration to zero gains, full output range and unlimited step.
//   The user writes configuration through csr_ while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module velocity_pid_with_slew_limit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  vpid_pkg::word_type             req_sample_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output vpid_pkg::word_type             rsp_drive,
   output logic                           rsp_range_limited,
   output logic                           rsp_step_limited,
   input  logic                           csr_write,
   input  vpid_pkg::csr_index_type        csr_index,
   input  logic [vpid_pkg::DATA_WIDTH-1:0] csr_wdata
);
   import vpid_pkg::*;

   localparam int QW   = DATA_WIDTH + 2;        // combined gain width
   localparam int PW   = QW + DATA_WIDTH;       // product width
   localparam int SW   = PW + 2;                // sum of three products
   localparam int DW   = DATA_WIDTH + 2;        // drive difference width

   // Configuration registers.
   word_type kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   word_type target_ff, target_in, min_ff, min_in, max_ff, max_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic signed [QW-1:0] q0_ff, q0_in, q1_ff, q1_in;

   // Controller state.
   word_type last_ff, last_in, e1_ff, e1_in, e2_ff, e2_in;

   // Input register.
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_func_ff, s1_func_in;
   word_type s1_sample_ff, s1_sample_in;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   word_type drive_ff, drive_in;
   logic     range_ff, range_in, step_lim_ff, step_lim_in;

   logic advance;
   logic req_take;

   logic signed [DATA_WIDTH:0] err_wide;
   word_type                   err;
   logic signed [PW-1:0]       prod0, prod1, prod2;
   logic signed [SW-1:0]       sum, sum_shift, y_full;
   word_type                   y_clamp;
   logic signed [DW-1:0]       diff, step_s, drive_wide;

   // ------------------------------------------------------------------
   // Configuration. The combined gains are kept registered alongside the
   // raw gains, built from the values being written in the same cycle.
   // ------------------------------------------------------------------
   always_comb begin
      kp_in     = kp_ff;
      ki_in     = ki_ff;
      kd_in     = kd_ff;
      target_in = target_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      step_in   = step_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PROPORTIONAL_GAIN: kp_in     = signed'(csr_wdata);
            CSR_INTEGRAL_GAIN:     ki_in     = signed'(csr_wdata);
            CSR_DERIVATIVE_GAIN:   kd_in     = signed'(csr_wdata);
            CSR_TARGET_LEVEL:      target_in = signed'(csr_wdata);
            CSR_MIN_OUTPUT:        min_in    = signed'(csr_wdata);
            CSR_MAX_OUTPUT:        max_in    = signed'(csr_wdata);
            CSR_MAX_STEP:          step_in   = csr_wdata[STEP_WIDTH-1:0];
            default: ;
         endcase
      end
      q0_in = QW'(kp_in) + QW'(ki_in) + QW'(kd_in);
      q1_in = -QW'(kp_in) - (QW'(kd_in) <<< 1);
   end

   // ------------------------------------------------------------------
   // Handshake: the input register moves on whenever the result register
   // is empty or its beat is being taken.
   // ------------------------------------------------------------------
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_func_in   = s1_func_ff;
      s1_sample_in = s1_sample_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in  = 1'b1;
         s1_func_in   = req_func;
         s1_sample_in = req_sample_value;
      end
   end

   // ------------------------------------------------------------------
   // Datapath.
   // ------------------------------------------------------------------
   always_comb begin
      err_wide = (DATA_WIDTH+1)'(target_ff) - (DATA_WIDTH+1)'(s1_sample_ff);
      if (err_wide[DATA_WIDTH] != err_wide[DATA_WIDTH-1]) begin
         err = err_wide[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
      end else begin
         err = err_wide[DATA_WIDTH-1:0];
      end

      prod0 = PW'(q0_ff) * PW'(err);
      prod1 = PW'(q1_ff) * PW'(e1_ff);
      prod2 = PW'(kd_ff) * PW'(e2_ff);
      sum   = SW'(prod0) + SW'(prod1) + SW'(prod2);

      // One arithmetic shift of the exact sum rounds towards minus infinity.
      sum_shift = sum >>> FRAC_BITS;
      y_full    = sum_shift + SW'(last_ff);

      range_in = 1'b0;
      priority if (y_full > SW'(max_ff)) begin
         y_clamp  = max_ff;
         range_in = 1'b1;
      end else if (y_full < SW'(min_ff)) begin
         y_clamp  = min_ff;
         range_in = 1'b1;
      end else begin
         y_clamp = y_full[DATA_WIDTH-1:0];
      end

      diff        = DW'(y_clamp) - DW'(last_ff);
      step_s      = signed'(DW'(step_ff));
      step_lim_in = 1'b0;
      priority if (diff > step_s) begin
         drive_wide  = DW'(last_ff) + step_s;
         step_lim_in = 1'b1;
      end else if (-diff > step_s) begin
         drive_wide  = DW'(last_ff) - step_s;
         step_lim_in = 1'b1;
      end else begin
         drive_wide = DW'(y_clamp);
      end

      drive_in = drive_wide[DATA_WIDTH-1:0];
      e1_in    = err;
      e2_in    = e1_ff;

      if (s1_func_ff == FUNC_RESTART) begin
         drive_in    = (ki_ff != '0) ? s1_sample_ff : '0;
         range_in    = 1'b0;
         step_lim_in = 1'b0;
         e1_in       = '0;
         e2_in       = '0;
      end

      last_in = drive_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         target_ff    <= '0;
         min_ff       <= WORD_MIN;
         max_ff       <= WORD_MAX;
         step_ff      <= STEP_MAX;
         q0_ff        <= '0;
         q1_ff        <= '0;
         last_ff      <= '0;
         e1_ff        <= '0;
         e2_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         target_ff    <= target_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         step_ff      <= step_in;
         q0_ff        <= q0_in;
         q1_ff        <= q1_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && s1_valid_ff) begin
            last_ff <= last_in;
            e1_ff   <= e1_in;
            e2_ff   <= e2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_func_ff   <= s1_func_in;
      s1_sample_ff <= s1_sample_in;
      if (advance && s1_valid_ff) begin
         drive_ff    <= drive_in;
         range_ff    <= range_in;
         step_lim_ff <= step_lim_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = drive_ff;
   assign rsp_range_limited = range_ff;
   assign rsp_step_limited  = step_lim_ff;

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
   // A restart beat leaves both stored errors cleared.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_func_ff == FUNC_RESTART)
      |=> (e1_ff == '0 && e2_ff == '0))
      else $error("restart did not clear the error history");

   // A sample beat never moves the drive by more than the step limit.
   a_slew_bound: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_func_ff == FUNC_SAMPLE)
      |-> ((DW'(drive_in) - DW'(last_ff)) <= step_s
           && (DW'(last_ff) - DW'(drive_in)) <= step_s))
      else $error("drive change exceeds the step limit");

   // A range-limited beat that was not slewed sits on one of the limits.
   a_range_on_limit: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && range_in && !step_lim_in)
      |-> (drive_in == max_ff || drive_in == min_ff))
      else $error("range flag set but drive is not on a limit");

   // The stored drive follows each result beat as it is loaded.
   a_state_tracks_result: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff) |=> (rsp_valid_ff && last_ff == drive_ff))
      else $error("stored drive and result register disagree");

endmodule

// ----- sim/tb_velocity_pid_with_slew_limit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_velocity_pid_with_slew_limit
// Self-checking bench for the incremental PID block with slew limiting.
// A bit-exact controller model is updated on every accepted request beat,
// and every response beat is compared against the oldest predicted drive.
// Directed cases come first, then random phases with fresh register settings
// and random idling on both channels, then a long response hold-off.
// ----------------------------------------------------------------------------
module tb_velocity_pid_with_slew_limit;
   import vpid_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam csr_index_type CSR_UNUSED = 3'd7;
   localparam word_type ONE = 32'sh0001_0000;

   typedef struct packed {
      word_type drive;
      logic     range_limited;
      logic     step_limited;
   } drive_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_func;
   word_type              req_sample_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   word_type              rsp_drive;
   logic                  rsp_range_limited;
   logic                  rsp_step_limited;
   logic                  csr_write;
   csr_index_type         csr_index;
   logic [DATA_WIDTH-1:0] csr_wdata;

   // Controller model: settings and state as they stand in the block.
   word_type              cfg_kp = '0;
   word_type              cfg_ki = '0;
   word_type              cfg_kd = '0;
   word_type              cfg_target = '0;
   word_type              cfg_min = WORD_MIN;
   word_type              cfg_max = WORD_MAX;
   logic [STEP_WIDTH-1:0] cfg_step = STEP_MAX;
   word_type              model_drive = '0;
   word_type              model_err1 = '0;
   word_type              model_err2 = '0;

   drive_beat_type pending_drives[$];

   int items_sent = 0;
   int restarts_sent = 0;
   int results_checked = 0;
   int range_hits = 0;
   int step_hits = 0;
   int input_stall_cycles = 0;
   int mismatch_count = 0;
   int hold_left = 0;
   bit quiet_req = 0;
   bit quiet_rsp = 0;

   velocity_pid_with_slew_limit #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive        (rsp_drive),
      .rsp_range_limited(rsp_range_limited),
      .rsp_step_limited (rsp_step_limited),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Works out the beat that one request produces and moves the model on.
   function automatic drive_beat_type advance_controller(logic func, word_type value);
      drive_beat_type     beat;
      logic signed [32:0] err_wide;
      word_type           err;
      logic signed [71:0] kp_w, ki_w, kd_w, e_w, e1_w, e2_w;
      logic signed [71:0] acc, level, last_w, min_w, max_w, diff, step_w;
      beat.range_limited = 1'b0;
      beat.step_limited = 1'b0;
      if (func == FUNC_RESTART) begin
         model_drive = (cfg_ki != 0) ? value : '0;
         model_err1 = '0;
         model_err2 = '0;
      end else begin
         err_wide = cfg_target;
         err_wide = err_wide - value;
         // The difference saturates rather than wraps.
         if (err_wide[32] != err_wide[31]) err = err_wide[32] ? WORD_MIN : WORD_MAX;
         else err = err_wide[31:0];
         kp_w = cfg_kp;
         ki_w = cfg_ki;
         kd_w = cfg_kd;
         e_w = err;
         e1_w = model_err1;
         e2_w = model_err2;
         acc = kp_w * e_w + ki_w * e_w + kd_w * e_w
               - kp_w * e1_w - kd_w * e1_w - kd_w * e1_w + kd_w * e2_w;
         last_w = model_drive;
         min_w = cfg_min;
         max_w = cfg_max;
         step_w = cfg_step;
         level = last_w + (acc >>> FRAC_BITS);
         if (level > max_w) begin
            level = max_w;
            beat.range_limited = 1'b1;
         end else if (level < min_w) begin
            level = min_w;
            beat.range_limited = 1'b1;
         end
         diff = level - last_w;
         if (diff > step_w) begin
            level = last_w + step_w;
            beat.step_limited = 1'b1;
         end else if (-diff > step_w) begin
            level = last_w - step_w;
            beat.step_limited = 1'b1;
         end
         model_drive = level[31:0];
         model_err2 = model_err1;
         model_err1 = err;
      end
      beat.drive = model_drive;
      return beat;
   endfunction

   // Watches all three ports at each edge: checks responses, tracks register
   // writes and predicts the beat for each accepted request.
   always @(posedge clock) begin : drive_check
      drive_beat_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_drives.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing pending, drive %h",
                                         rsp_drive));
            end else begin
               want = pending_drives.pop_front();
               results_checked++;
               if (want.range_limited) range_hits++;
               if (want.step_limited) step_hits++;
               if (rsp_drive !== want.drive)
                  report_mismatch($sformatf("beat %0d drive %h, predicted %h",
                                            results_checked, rsp_drive, want.drive));
               if (rsp_range_limited !== want.range_limited)
                  report_mismatch($sformatf("beat %0d range flag %b, predicted %b",
                                            results_checked, rsp_range_limited,
                                            want.range_limited));
               if (rsp_step_limited !== want.step_limited)
                  report_mismatch($sformatf("beat %0d step flag %b, predicted %b",
                                            results_checked, rsp_step_limited,
                                            want.step_limited));
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_PROPORTIONAL_GAIN: cfg_kp = csr_wdata;
               CSR_INTEGRAL_GAIN:     cfg_ki = csr_wdata;
               CSR_DERIVATIVE_GAIN:   cfg_kd = csr_wdata;
               CSR_TARGET_LEVEL:      cfg_target = csr_wdata;
               CSR_MIN_OUTPUT:        cfg_min = csr_wdata;
               CSR_MAX_OUTPUT:        cfg_max = csr_wdata;
               CSR_MAX_STEP:          cfg_step = csr_wdata[STEP_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_drives.push_back(advance_controller(req_func, req_sample_value));
      end
   end

   // Response side idling: short bursts mostly, now and then a long one, and
   // the long hold-off when one is requested.
   initial begin : rsp_stall_gen
      int stall_left;
      int free_left;
      int r;
      stall_left = 0;
      free_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (free_left > 0 || quiet_rsp) begin
            rsp_stall <= 1'b0;
            if (free_left > 0) free_left--;
         end else begin
            rsp_stall <= 1'b0;
            r = $urandom_range(0, 99);
            free_left = $urandom_range(0, 8);
            if (r < 85) stall_left = $urandom_range(1, 3);
            else if (r < 97) stall_left = $urandom_range(4, 10);
            else stall_left = $urandom_range(20, 60);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_req || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   // Offers one request beat and returns at the edge where it is taken.
   task automatic send_item(input logic func, input word_type value);
      int gap;
      gap = pick_gap();
      csr_write <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_sample_value <= value;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (func == FUNC_RESTART) restarts_sent++;
   endtask

   // Leaves the write enable high; the next request beat lowers it.
   task automatic write_register(input csr_index_type index, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_checked < items_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic word_type gain_pick();
      word_type mag;
      mag = $urandom_range(0, 32'h0004_0000);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom;
         default: return $urandom_range(0, 1) ? -mag : mag;
      endcase
   endfunction

   task automatic test_after_reset();
      // Zero gains: the drive must stay at zero, and a restart without an
      // integral term loads zero.
      send_item(FUNC_SAMPLE, ONE);
      send_item(FUNC_SAMPLE, WORD_MIN);
      send_item(FUNC_RESTART, WORD_MAX);
   endtask

   task automatic test_directed_cases();
      wait_idle();
      write_register(CSR_PROPORTIONAL_GAIN, ONE);
      write_register(CSR_INTEGRAL_GAIN, 32'sh0000_8000);
      write_register(CSR_DERIVATIVE_GAIN, 32'sh0000_4000);
      write_register(CSR_MIN_OUTPUT, 32'shFF9C_0000);
      write_register(CSR_MAX_OUTPUT, 32'sh0064_0000);
      write_register(CSR_UNUSED, 32'hDEAD_BEEF);
      send_item(FUNC_RESTART, 32'sh0005_0000);
      send_item(FUNC_SAMPLE, ONE);
      send_item(FUNC_SAMPLE, 32'shFFFE_0000);
      send_item(FUNC_SAMPLE, 32'sh0003_0000);

      // Error saturation in both directions, landing on the output clamp.
      wait_idle();
      write_register(CSR_TARGET_LEVEL, WORD_MAX);
      send_item(FUNC_SAMPLE, WORD_MIN);
      wait_idle();
      write_register(CSR_TARGET_LEVEL, WORD_MIN);
      send_item(FUNC_SAMPLE, WORD_MAX);

      // Extreme gains push the sum far beyond 32 bits.
      wait_idle();
      write_register(CSR_PROPORTIONAL_GAIN, WORD_MAX);
      write_register(CSR_INTEGRAL_GAIN, WORD_MAX);
      write_register(CSR_DERIVATIVE_GAIN, WORD_MIN);
      write_register(CSR_TARGET_LEVEL, '0);
      write_register(CSR_MIN_OUTPUT, WORD_MIN);
      write_register(CSR_MAX_OUTPUT, WORD_MAX);
      send_item(FUNC_SAMPLE, WORD_MAX);
      send_item(FUNC_SAMPLE, WORD_MIN);
      send_item(FUNC_SAMPLE, WORD_MAX);
      send_item(FUNC_SAMPLE, '0);

      // Minimum set above maximum: both clamp branches must be taken.
      wait_idle();
      write_register(CSR_PROPORTIONAL_GAIN, ONE);
      write_register(CSR_INTEGRAL_GAIN, '0);
      write_register(CSR_DERIVATIVE_GAIN, '0);
      write_register(CSR_MIN_OUTPUT, 32'sh000A_0000);
      write_register(CSR_MAX_OUTPUT, 32'shFFF6_0000);
      send_item(FUNC_SAMPLE, 32'shFFCE_0000);
      send_item(FUNC_SAMPLE, 32'sh0032_0000);
      send_item(FUNC_RESTART, 32'sh0007_0000);
      send_item(FUNC_SAMPLE, '0);

      // Slew limit of zero freezes the drive; the top data bit is dropped.
      wait_idle();
      write_register(CSR_MIN_OUTPUT, WORD_MIN);
      write_register(CSR_MAX_OUTPUT, WORD_MAX);
      write_register(CSR_MAX_STEP, '0);
      send_item(FUNC_SAMPLE, 32'sh0005_0000);
      send_item(FUNC_SAMPLE, 32'shFFFB_0000);
      wait_idle();
      write_register(CSR_MAX_STEP, 32'h8001_0000);
      send_item(FUNC_SAMPLE, 32'sh0014_0000);
      send_item(FUNC_SAMPLE, 32'shFFEC_0000);

      // Restarts with an integral term load the start value itself.
      wait_idle();
      write_register(CSR_INTEGRAL_GAIN, ONE);
      send_item(FUNC_RESTART, WORD_MIN);
      send_item(FUNC_SAMPLE, 32'sh0002_0000);
      send_item(FUNC_RESTART, WORD_MAX);
   endtask

   task automatic test_random_phases();
      word_type    kp, ki, kd, target, lo, hi, a, b, value;
      logic [31:0] step_data;
      int          choice;
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         kp = gain_pick();
         ki = gain_pick();
         kd = gain_pick();
         if (p == 2) begin
            kp = WORD_MAX;
            ki = WORD_MIN;
            kd = WORD_MIN;
         end
         target = ($urandom_range(0, 3) == 0) ? word_type'($urandom)
                                              : word_type'($urandom_range(0, 32'h00FF_FFFF));
         choice = (p == 0) ? 0 : $urandom_range(0, 3);
         case (choice)
            0: begin
               lo = WORD_MIN;
               hi = WORD_MAX;
            end
            1: begin
               a = $urandom_range(0, 300);
               b = $urandom_range(0, 300);
               lo = -(a <<< FRAC_BITS);
               hi = b <<< FRAC_BITS;
            end
            default: begin
               a = $urandom;
               b = $urandom;
               // Choice 3 deliberately leaves the minimum above the maximum.
               if ((a < b) == (choice == 2)) begin
                  lo = a;
                  hi = b;
               end else begin
                  lo = b;
                  hi = a;
               end
            end
         endcase
         step_data = $urandom;
         case ($urandom_range(0, 3))
            0: step_data[30:0] = STEP_MAX;
            1: step_data[30:0] = $urandom_range(0, 32'h0008_0000);
            2: step_data[30:0] = $urandom_range(0, 15);
            default: ;
         endcase
         if (p == 0) step_data[30:0] = STEP_MAX;
         if (p == 1) step_data[30:0] = '0;
         write_register(CSR_PROPORTIONAL_GAIN, kp);
         write_register(CSR_INTEGRAL_GAIN, ki);
         write_register(CSR_DERIVATIVE_GAIN, kd);
         write_register(CSR_TARGET_LEVEL, target);
         write_register(CSR_MIN_OUTPUT, lo);
         write_register(CSR_MAX_OUTPUT, hi);
         write_register(CSR_MAX_STEP, step_data);
         quiet_req = (p == 3);
         quiet_rsp = (p == 3 || p == 6);
         for (int i = 0; i < 100; i++) begin
            case ($urandom_range(0, 19))
               0: value = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
               1, 2, 3, 4: value = $urandom;
               default: begin
                  a = $urandom_range(0, 32'h0020_0000);
                  value = target + a - 32'sh0010_0000;
               end
            endcase
            send_item(($urandom_range(0, 99) < 8) ? FUNC_RESTART : FUNC_SAMPLE, value);
         end
      end
      quiet_req = 0;
      quiet_rsp = 0;
   endtask

   task automatic test_backpressure();
      word_type value;
      wait_idle();
      // The receiver holds off while requests keep coming back to back, so
      // the block has to fill and push back on its input.
      quiet_req = 1;
      hold_left = 300;
      for (int i = 0; i < 30; i++) begin
         value = $urandom;
         send_item(($urandom_range(0, 9) == 0) ? FUNC_RESTART : FUNC_SAMPLE, value);
      end
      quiet_req = 0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_SAMPLE;
      req_sample_value <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_PROPORTIONAL_GAIN;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_directed_cases();
      test_random_phases();
      test_backpressure();

      wait_idle();
      repeat (10) @(posedge clock);
      if (pending_drives.size() != 0)
         report_mismatch($sformatf("%0d predicted beats never arrived", pending_drives.size()));
      $display("summary: %0d request beats (%0d restarts), %0d response beats checked",
               items_sent, restarts_sent, results_checked);
      $display("summary: %0d range clamps, %0d slew limits, %0d input stall cycles, %0d errors",
               range_hits, step_hits, input_stall_cycles, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
